// File: hw/rtl/hoamix_pkg.sv
package hoamix_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CHANNELS = 4;
  localparam int LANES_DEFAULT = 4;
  localparam int COEF_BITS_DEFAULT = 16;
  localparam int COEF_SLOT_BITS = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;

  typedef enum logic [2:0] {
    REG_ACTIVE_SIZE = 3'd0,
    REG_BYPASS_MODE = 3'd1,
    REG_ZERO_MASK   = 3'd2,
    REG_ROW_ZERO    = 3'd3,
    REG_ROW_ONE     = 3'd4,
    REG_ROW_TWO     = 3'd5,
    REG_ROW_THREE   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic signed [SAMPLE_BITS-1:0] sample_c;
    logic signed [SAMPLE_BITS-1:0] sample_d;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_a;
    logic signed [SAMPLE_BITS-1:0] out_b;
    logic signed [SAMPLE_BITS-1:0] out_c;
    logic signed [SAMPLE_BITS-1:0] out_d;
    logic                          frame_end_out;
  } out_item_t;

endpackage

// File: hw/rtl/hoamix_row.sv
module hoamix_row #(
  parameter int COEF_BITS = hoamix_pkg::COEF_BITS_DEFAULT
) (
  input  logic                                                   clk,
  input  logic                                                   en,
  input  logic signed [hoamix_pkg::CHANNELS-1:0][hoamix_pkg::SAMPLE_BITS-1:0] x,
  input  logic signed [hoamix_pkg::CHANNELS-1:0][COEF_BITS-1:0]  coef,
  output logic signed [hoamix_pkg::SAMPLE_BITS-1:0]              y
);
  import hoamix_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS = PROD_BITS + 2;
  localparam int FRAC = COEF_BITS - 2;
  localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [ACC_BITS-1:0] HI = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_BITS-1:0] LO = -HI - ACC_BITS'(1);

  logic signed [PROD_BITS-1:0] prod [CHANNELS];
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  rounded;
  logic signed [ACC_BITS-1:0]  shifted;
  logic signed [ACC_BITS-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prod[c] <= PROD_BITS'($signed(x[c])) * PROD_BITS'($signed(coef[c]));
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum_next = sum_next + ACC_BITS'(prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= sum_next;
    end
  end

  // Round to nearest with ties toward plus infinity, then clamp.
  assign rounded = acc + HALF;
  assign shifted = rounded >>> FRAC;

  always_ff @(posedge clk) begin
    if (en) begin
      if (shifted > HI) begin
        y <= HI[SAMPLE_BITS-1:0];
      end else if (shifted < LO) begin
        y <= LO[SAMPLE_BITS-1:0];
      end else begin
        y <= shifted[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// File: hw/rtl/hoa_low_order_matrix_mix.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_stall       in_item (in_item_t)
// out       output     out_valid / out_stall     out_item (out_item_t)
// cfg       input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One item can enter every cycle while in_stall is low.
// The four stages are input masking, products, row sums, rounding and clamping.
// A stall on the output while out_valid is high freezes the whole pipeline and holds in_stall high.
// Reset clears the valid bits and loads the register reset values.
// In bypass mode items are taken and dropped without a result.
module hoa_low_order_matrix_mix #(
  parameter int LANES = hoamix_pkg::LANES_DEFAULT,
  parameter int COEF_BITS = hoamix_pkg::COEF_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  hoamix_pkg::in_item_t                  in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output hoamix_pkg::out_item_t                 out_item,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hoamix_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [hoamix_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [hoamix_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                  pready
);
  import hoamix_pkg::*;

  localparam int DEPTH = 4;

  logic [2:0]                   active_size;
  logic                         bypass_mode;
  logic [CHANNELS-1:0]          zero_mask;
  logic [CFG_DATA_BITS-1:0]     row_coeffs [CHANNELS];

  reg_index_t                   reg_index;
  logic [2:0]                   lanes_used;

  logic                         en;
  logic [DEPTH-1:0]             valid;
  logic [DEPTH-1:0]             frame_end;

  logic signed [CHANNELS-1:0][SAMPLE_BITS-1:0] x_next;
  logic signed [CHANNELS-1:0][SAMPLE_BITS-1:0] x;
  logic signed [CHANNELS-1:0][CHANNELS-1:0][COEF_BITS-1:0] coef_next;
  logic signed [CHANNELS-1:0][CHANNELS-1:0][COEF_BITS-1:0] coef;
  logic signed [CHANNELS-1:0][SAMPLE_BITS-1:0] y;

  assign reg_index = reg_index_t'(paddr[CFG_ADDR_BITS-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= 3'd4;
      bypass_mode <= 1'b0;
      zero_mask <= '0;
      for (int r = 0; r < CHANNELS; r++) begin
        row_coeffs[r] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_ACTIVE_SIZE: active_size <= pwdata[2:0];
        REG_BYPASS_MODE: bypass_mode <= pwdata[0];
        REG_ZERO_MASK:   zero_mask <= pwdata[CHANNELS-1:0];
        REG_ROW_ZERO:    row_coeffs[0] <= pwdata;
        REG_ROW_ONE:     row_coeffs[1] <= pwdata;
        REG_ROW_TWO:     row_coeffs[2] <= pwdata;
        REG_ROW_THREE:   row_coeffs[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ACTIVE_SIZE: prdata = CFG_DATA_BITS'(active_size);
      REG_BYPASS_MODE: prdata = CFG_DATA_BITS'(bypass_mode);
      REG_ZERO_MASK:   prdata = CFG_DATA_BITS'(zero_mask);
      REG_ROW_ZERO:    prdata = row_coeffs[0];
      REG_ROW_ONE:     prdata = row_coeffs[1];
      REG_ROW_TWO:     prdata = row_coeffs[2];
      REG_ROW_THREE:   prdata = row_coeffs[3];
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (active_size == 3'd0) begin
      lanes_used = 3'd1;
    end else if (32'(active_size) > LANES) begin
      lanes_used = 3'(LANES);
    end else begin
      lanes_used = active_size;
    end
  end

  always_comb begin
    x_next[0] = in_item.sample_a;
    x_next[1] = in_item.sample_b;
    x_next[2] = in_item.sample_c;
    x_next[3] = in_item.sample_d;
    for (int c = 0; c < CHANNELS; c++) begin
      if (zero_mask[c] || c >= LANES) begin
        x_next[c] = '0;
      end
    end
    for (int r = 0; r < CHANNELS; r++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (r < 32'(lanes_used) && c < 32'(lanes_used)) begin
          coef_next[r][c] = row_coeffs[r][COEF_SLOT_BITS*c +: COEF_BITS];
        end else begin
          coef_next[r][c] = '0;
        end
      end
    end
  end

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[DEPTH-2:0], in_valid && !bypass_mode};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_end <= {frame_end[DEPTH-2:0], in_item.frame_end};
      x <= x_next;
      coef <= coef_next;
    end
  end

  for (genvar r = 0; r < CHANNELS; r++) begin : g_row
    hoamix_row #(
      .COEF_BITS(COEF_BITS)
    ) u_row (
      .clk (clk),
      .en  (en),
      .x   (x),
      .coef(coef[r]),
      .y   (y[r])
    );
  end

  assign out_valid = valid[DEPTH-1];
  assign out_item.out_a = y[0];
  assign out_item.out_b = y[1];
  assign out_item.out_c = y[2];
  assign out_item.out_d = y[3];
  assign out_item.frame_end_out = frame_end[DEPTH-1];

endmodule
